/* src/sampled_bitvector_rank_assert.svh */
// Assertion macros shared by the block's modules.
// They expect signals named clk and rst in the module that uses them.
`ifndef SAMPLED_BITVECTOR_RANK_ASSERT_SVH
`define SAMPLED_BITVECTOR_RANK_ASSERT_SVH

`define SBVR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define SBVR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sbvr_pkg.sv */
package sbvr_pkg;

  localparam int MAX_BYTES   = 65536;
  localparam int ADDR_W      = $clog2(MAX_BYTES);
  localparam int POS_W       = ADDR_W + 1;
  localparam int MAX_GROUP   = 64;
  localparam int GROUP_W     = 7;
  localparam int GROUP_RESET = 8;
  localparam int ONES_W      = 20;
  localparam int RANK_W      = 19;
  localparam int INDEX_W     = 19;
  localparam int ACTION_W    = 2;
  localparam int BYTE_W      = 8;
  localparam int SHIFT_W     = 3;
  localparam int XBYTE_W     = INDEX_W - SHIFT_W;
  localparam int STEP_W      = $clog2(ADDR_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_QUERY,
    CMD_FIXED
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    logic [ONES_W-1:0]   ones;
    logic [SHIFT_W-1:0]  shift;
    logic                oor;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_FETCH,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FINAL,
    ST_DONE
  } back_state_t;

  function automatic logic [3:0] pop8(input logic [BYTE_W-1:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      n = n + {3'b000, b[k]};
    end
    return n;
  endfunction

endpackage

/* src/sbvr_item_if.sv */
interface sbvr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  byte_value;
  logic [18:0] bit_index;

  modport source (output valid, action, byte_value, bit_index, input ready);
  modport sink (input valid, action, byte_value, bit_index, output ready);
endinterface

/* src/sbvr_result_if.sv */
interface sbvr_result_if;
  logic        valid;
  logic        ready;
  logic        is_set;
  logic [18:0] rank;
  logic        out_of_range;

  modport source (output valid, is_set, rank, out_of_range, input ready);
  modport sink (input valid, is_set, rank, out_of_range, output ready);
endinterface

/* src/sampled_bitvector_rank.sv */
// Clear, ignored and out-of-range items go straight to the result. Appends pass through
// the 16-step divider, then write the byte and, at a group start, the sample. Queries
// divide too, then read the byte and its sample; a clear bit ends there, a set bit two or
// more bytes past the sample byte first scans the bytes in between, then the rank is formed.
// The back end takes one item at a time, behind a two-entry queue.
// Reset (rst, synchronous, active high) empties the vector and sets the group to eight bytes.
module sampled_bitvector_rank (
  input  logic                          clk,
  input  logic                          rst,
  sbvr_item_if.sink                     item,
  sbvr_result_if.source                 result,
  input  logic                          cfg_we,
  input  logic [sbvr_pkg::GROUP_W-1:0]  cfg_wdata
);
  import sbvr_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, empty;

  sbvr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .push_cmd (push_cmd),
    .push     (push),
    .full     (full)
  );

  sbvr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  sbvr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (pop_cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* src/sbvr_front.sv */
`include "sampled_bitvector_rank_assert.svh"

module sbvr_front (
  input  logic          clk,
  input  logic          rst,
  sbvr_item_if.sink     item,
  output sbvr_pkg::cmd_t push_cmd,
  output logic          push,
  input  logic          full
);
  import sbvr_pkg::*;

  logic [POS_W-1:0]   lp, lp_next;
  logic [ONES_W-1:0]  ones, ones_next;
  logic [ONES_W-1:0]  ones_sum;
  logic [XBYTE_W-1:0] x;

  always_comb begin
    item.ready = !full;
    push       = item.valid && !full;
    x          = item.bit_index[INDEX_W-1:SHIFT_W];
    ones_sum   = ones + ONES_W'(pop8(item.byte_value));
    lp_next    = lp;
    ones_next  = ones;
    push_cmd.kind  = CMD_FIXED;
    push_cmd.addr  = lp[ADDR_W-1:0];
    push_cmd.data  = item.byte_value;
    push_cmd.ones  = ones_sum;
    push_cmd.shift = item.bit_index[SHIFT_W-1:0];
    push_cmd.oor   = 1'b0;
    case (item.action)
      ACT_APPEND: begin
        if (32'(lp) >= 32'(MAX_BYTES)) begin
          push_cmd.oor = 1'b1;
        end else begin
          push_cmd.kind = CMD_APPEND;
          lp_next       = lp + POS_W'(1);
          ones_next     = ones_sum;
        end
      end
      ACT_QUERY: begin
        push_cmd.addr = ADDR_W'(x);
        if (32'(x) >= 32'(lp)) begin
          push_cmd.oor = 1'b1;
        end else begin
          push_cmd.kind = CMD_QUERY;
        end
      end
      ACT_CLEAR: begin
        lp_next   = '0;
        ones_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp   <= '0;
      ones <= '0;
    end else if (push) begin
      lp   <= lp_next;
      ones <= ones_next;
    end
  end

  `SBVR_ASSERT_IMP(a_lp_bound, 1'b1, 32'(lp) <= 32'(MAX_BYTES), "load position past capacity")

endmodule

/* src/sbvr_queue.sv */
`include "sampled_bitvector_rank_assert.svh"

module sbvr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbvr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sbvr_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import sbvr_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  `SBVR_ASSERT_IMP(a_no_overflow, push, !full || pop, "push into a full queue")
  `SBVR_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from an empty queue")

endmodule

/* src/sbvr_back.sv */
`include "sampled_bitvector_rank_assert.svh"

module sbvr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sbvr_pkg::GROUP_W-1:0]  cfg_wdata,
  input  sbvr_pkg::cmd_t                cmd,
  input  logic                          empty,
  output logic                          pop,
  sbvr_result_if.source                 result
);
  import sbvr_pkg::*;

  logic [BYTE_W-1:0] bit_mem    [MAX_BYTES];
  logic [ONES_W-1:0] sample_mem [MAX_BYTES];

  back_state_t        state, state_next;
  cmd_t               cur_cmd;
  logic [GROUP_W-1:0] group, g;
  logic [ADDR_W-1:0]  dq;
  logic [GROUP_W-1:0] rem, rem_step;
  logic [GROUP_W:0]   trial;
  logic               ge;
  logic [STEP_W-1:0]  step;
  logic [ADDR_W:0]    ptr;
  logic               rd_pend;
  logic [ONES_W-1:0]  acc, final_ones;
  logic [BYTE_W-1:0]  cur_byte, low_mask;
  logic [BYTE_W-1:0]  bit_rdata;
  logic [ONES_W-1:0]  sample_rdata;
  logic               bit_we, bit_re, sample_we, sample_re;
  logic [ADDR_W-1:0]  bit_raddr;
  logic               res_is_set, res_oor;
  logic [RANK_W-1:0]  res_rank;
  logic               out_valid, out_is_set, out_oor;
  logic [RANK_W-1:0]  out_rank;
  logic               slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      group <= GROUP_W'(GROUP_RESET);
    end else if (cfg_we) begin
      group <= cfg_wdata;
    end
  end

  always_comb begin
    if (group == '0) begin
      g = GROUP_W'(1);
    end else if (group > GROUP_W'(MAX_GROUP)) begin
      g = GROUP_W'(MAX_GROUP);
    end else begin
      g = group;
    end
  end

  always_comb begin
    trial    = {rem, dq[ADDR_W-1]};
    ge       = (trial >= {1'b0, g});
    rem_step = ge ? GROUP_W'(trial - {1'b0, g}) : trial[GROUP_W-1:0];
  end

  always_comb begin
    low_mask = BYTE_W'((9'd2 << cur_cmd.shift) - 9'd1);
    if (rem != '0) begin
      final_ones = acc + ONES_W'(pop8(cur_byte & low_mask));
    end else begin
      final_ones = acc - ONES_W'(pop8(cur_byte >> ({1'b0, cur_cmd.shift} + 4'd1)));
    end
  end

  assign slot_free = !out_valid || result.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          state_next = (cmd.kind == CMD_FIXED) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == STEP_W'(ADDR_W - 1)) begin
          state_next = (cur_cmd.kind == CMD_APPEND) ? ST_WRITE : ST_FETCH;
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_FETCH: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!bit_rdata[cur_cmd.shift]) begin
          state_next = ST_DONE;
        end else if (ptr < {1'b0, cur_cmd.addr}) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_SCAN: begin
        if (ptr + (ADDR_W + 1)'(1) == {1'b0, cur_cmd.addr}) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FINAL;
      ST_FINAL: state_next = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == ST_IDLE) && !empty;
    bit_we    = (state == ST_WRITE);
    sample_we = (state == ST_WRITE) && (rem == '0);
    bit_re    = (state == ST_FETCH) || (state == ST_SCAN);
    sample_re = (state == ST_FETCH);
    bit_raddr = (state == ST_FETCH) ? cur_cmd.addr : ptr[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (bit_we) begin
      bit_mem[cur_cmd.addr] <= cur_cmd.data;
    end
    if (bit_re) begin
      bit_rdata <= bit_mem[bit_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sample_we) begin
      sample_mem[dq] <= cur_cmd.ones;
    end
    if (sample_re) begin
      sample_rdata <= sample_mem[dq];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          cur_cmd    <= cmd;
          dq         <= cmd.addr;
          rem        <= '0;
          step       <= '0;
          res_is_set <= 1'b0;
          res_rank   <= '0;
          res_oor    <= cmd.oor;
        end
      end
      ST_DIV: begin
        dq   <= {dq[ADDR_W-2:0], ge};
        rem  <= rem_step;
        step <= step + STEP_W'(1);
      end
      ST_FETCH: begin
        ptr <= {1'b0, cur_cmd.addr} - (ADDR_W + 1)'(rem) + (ADDR_W + 1)'(1);
      end
      ST_CHECK: begin
        cur_byte   <= bit_rdata;
        acc        <= sample_rdata;
        rd_pend    <= 1'b0;
        res_is_set <= bit_rdata[cur_cmd.shift];
      end
      ST_SCAN: begin
        ptr     <= ptr + (ADDR_W + 1)'(1);
        rd_pend <= 1'b1;
        if (rd_pend) begin
          acc <= acc + ONES_W'(pop8(bit_rdata));
        end
      end
      ST_DRAIN: begin
        rd_pend <= 1'b0;
        if (rd_pend) begin
          acc <= acc + ONES_W'(pop8(bit_rdata));
        end
      end
      ST_FINAL: begin
        res_rank <= RANK_W'(final_ones - ONES_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && slot_free) begin
      out_is_set <= res_is_set;
      out_rank   <= res_rank;
      out_oor    <= res_oor;
    end
  end

  assign result.valid        = out_valid;
  assign result.is_set       = out_is_set;
  assign result.rank         = out_rank;
  assign result.out_of_range = out_oor;

  `SBVR_ASSERT_IMP(a_rem_below_group, state == ST_DIV, rem < g, "remainder not below group")
  `SBVR_ASSERT_IMP(a_scan_bound, state == ST_SCAN, ptr < {1'b0, cur_cmd.addr}, "scan past byte")
  `SBVR_ASSERT_IMP(a_set_in_range, out_valid, !(out_is_set && out_oor), "set bit out of range")

endmodule

/* verif/sbvr_rank_checker.sv */
module sbvr_rank_checker (
  input  logic                          clk,
  input  logic                          rst,
  sbvr_item_if                          item_mon,
  sbvr_result_if                        result_mon,
  input  logic                          cfg_we,
  input  logic [sbvr_pkg::GROUP_W-1:0]  cfg_wdata,
  output int unsigned                   outstanding,
  output int unsigned                   fail_count
);
  import sbvr_pkg::*;

  typedef struct packed {
    logic              is_set;
    logic [RANK_W-1:0] rank;
    logic              out_of_range;
  } rank_reply_t;

  rank_reply_t        replies_due[$];
  logic [BYTE_W-1:0]  byte_mem [0:MAX_BYTES-1];
  logic [ONES_W-1:0]  sample_mem [0:MAX_BYTES-1];
  int unsigned        load_pos;
  logic [ONES_W-1:0]  ones_total;
  logic [GROUP_W-1:0] group_reg;

  function automatic rank_reply_t apply_item(input logic [ACTION_W-1:0] act,
                                             input logic [BYTE_W-1:0] bv,
                                             input logic [INDEX_W-1:0] bi);
    rank_reply_t reply;
    int unsigned g;
    int unsigned x;
    int unsigned y;
    int unsigned x1;
    int unsigned base;
    int unsigned acc;
    reply = '0;
    g = group_reg;
    if (g == 0) g = 1;
    if (g > MAX_GROUP) g = MAX_GROUP;
    case (act)
      ACT_APPEND: begin
        if (load_pos >= MAX_BYTES) begin
          reply.out_of_range = 1'b1;
        end else begin
          byte_mem[load_pos] = bv;
          ones_total = ones_total + ONES_W'($countones(bv));
          if (load_pos % g == 0) sample_mem[load_pos / g] = ones_total;
          load_pos = load_pos + 1;
        end
      end
      ACT_QUERY: begin
        x = bi >> 3;
        y = bi & 7;
        if (x >= load_pos) begin
          reply.out_of_range = 1'b1;
        end else if (byte_mem[x][y]) begin
          x1 = x / g;
          base = x1 * g;
          acc = sample_mem[x1];
          for (int unsigned b = base + 1; b < x; b++) acc += $countones(byte_mem[b]);
          if (x != base) begin
            acc += $countones(32'(byte_mem[x]) & ((32'd2 << y) - 32'd1));
          end else begin
            acc -= $countones(32'(byte_mem[x]) >> (y + 1));
          end
          reply.is_set = 1'b1;
          reply.rank = RANK_W'(acc - 1);
        end
      end
      ACT_CLEAR: begin
        load_pos = 0;
        ones_total = '0;
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    rank_reply_t want;
    if (rst) begin
      replies_due.delete();
      load_pos = 0;
      ones_total = '0;
      group_reg = GROUP_W'(GROUP_RESET);
      fail_count = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (replies_due.size() == 0) begin
          $error("result transfer arrived with no reply outstanding");
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (result_mon.is_set !== want.is_set) begin
            $error("is_set: expected %0d, actual %0d", want.is_set, result_mon.is_set);
            fail_count++;
          end
          if (result_mon.rank !== want.rank) begin
            $error("rank: expected %0d, actual %0d", want.rank, result_mon.rank);
            fail_count++;
          end
          if (result_mon.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, actual %0d", want.out_of_range,
                   result_mon.out_of_range);
            fail_count++;
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        replies_due.push_back(apply_item(item_mon.action, item_mon.byte_value,
                                         item_mon.bit_index));
      end
      if (cfg_we) group_reg = cfg_wdata;
    end
    outstanding <= replies_due.size();
  end

endmodule

/* verif/tb_sampled_bitvector_rank.sv */
module tb_sampled_bitvector_rank;
  import sbvr_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned INDEX_MAX = (1 << INDEX_W) - 1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [GROUP_W-1:0] cfg_wdata = '0;
  int unsigned        outstanding;
  int unsigned        fail_count;
  idle_mode_t         idle_mode = IDLE_NONE;
  int unsigned        send_gap_pct = 0;

  // Shadow of what has been loaded, so that queries never touch unwritten entries.
  logic [BYTE_W-1:0]  stim_bytes [0:MAX_BYTES-1];
  bit                 stim_sample_seen [0:MAX_BYTES-1];
  int unsigned        stim_pos = 0;
  int unsigned        stim_group = GROUP_RESET;

  sbvr_item_if   item_ch ();
  sbvr_result_if result_ch ();

  sampled_bitvector_rank u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sbvr_rank_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item_mon    (item_ch),
    .result_mon  (result_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: result_ch.ready <= ($urandom_range(99) >= 58);
      IDLE_BOTH: result_ch.ready <= ($urandom_range(99) >= 15);
      default:   result_ch.ready <= 1'b1;
    endcase
  end

  task automatic set_idle(input idle_mode_t mode);
    idle_mode <= mode;
    send_gap_pct = (mode == IDLE_SEND) ? 58 : (mode == IDLE_BOTH) ? 15 : 0;
  endtask

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] bv,
                           input logic [INDEX_W-1:0] bi);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.byte_value <= bv;
    item_ch.bit_index  <= bi;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    case (act)
      ACT_APPEND: begin
        if (stim_pos < MAX_BYTES) begin
          stim_bytes[stim_pos] = bv;
          if (stim_pos % stim_group == 0) stim_sample_seen[stim_pos / stim_group] = 1'b1;
          stim_pos++;
        end
      end
      ACT_CLEAR: stim_pos = 0;
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_group(input logic [GROUP_W-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    stim_group = (v == 0) ? 1 : (v > MAX_GROUP) ? MAX_GROUP : v;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned x;
    int unsigned y;
    int unsigned tries;
    bit ok;
    logic [BYTE_W-1:0] bv;
    logic [INDEX_W-1:0] noise;
    pick = $urandom_range(99);
    noise = INDEX_W'($urandom_range(INDEX_MAX));
    bv = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                  : BYTE_W'($urandom_range(255));
    ok = 1'b0;
    if (pick < 3 || (pick < 10 && stim_pos > 400)) begin
      send_item(ACT_CLEAR, bv, noise);
    end else if (pick < 5) begin
      send_item(ACT_UNUSED, bv, noise);
    end else if (pick < 45 || stim_pos >= MAX_BYTES) begin
      send_item(ACT_APPEND, bv, noise);
    end else begin
      if (pick < 90 && stim_pos != 0) begin
        for (tries = 0; tries < 8 && !ok; tries++) begin
          x = $urandom_range(stim_pos - 1);
          y = $urandom_range(7);
          ok = !stim_bytes[x][y] || stim_sample_seen[x / stim_group];
        end
      end
      if (ok) begin
        send_item(ACT_QUERY, bv, INDEX_W'(x * 8 + y));
      end else begin
        send_item(ACT_QUERY, bv, INDEX_W'($urandom_range(INDEX_MAX, stim_pos * 8)));
      end
    end
    if ($urandom_range(199) == 0) wait_drained();
  endtask

  initial begin
    logic [BYTE_W-1:0] first_bytes [10];
    logic [GROUP_W-1:0] phase_group;
    item_ch.valid = 1'b0;
    item_ch.action = ACT_APPEND;
    item_ch.byte_value = '0;
    item_ch.bit_index = '0;
    result_ch.ready = 1'b0;
    first_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h3C};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty vector, ignored action code, a short load and queries around it.
    send_item(ACT_QUERY, 8'h00, '0);
    send_item(ACT_UNUSED, 8'hFF, '1);
    foreach (first_bytes[i]) send_item(ACT_APPEND, first_bytes[i], '1);
    send_item(ACT_QUERY, 8'hFF, 19'd0);
    send_item(ACT_QUERY, 8'h00, 19'd8);
    send_item(ACT_QUERY, 8'h00, 19'd15);
    send_item(ACT_QUERY, 8'h00, 19'd16);
    send_item(ACT_QUERY, 8'h00, 19'd31);
    send_item(ACT_QUERY, 8'h00, 19'd64);
    send_item(ACT_QUERY, 8'h00, 19'd76);
    send_item(ACT_QUERY, 8'h00, 19'd80);
    send_item(ACT_QUERY, 8'h00, '1);
    send_item(ACT_CLEAR, 8'hFF, '1);
    send_item(ACT_QUERY, 8'h00, 19'd0);

    // Samples taken with one group size and read with another; the rank wraps.
    write_group(7'd1);
    send_item(ACT_CLEAR, 8'h00, '0);
    repeat (3) send_item(ACT_APPEND, 8'h00, '0);
    repeat (3) send_item(ACT_APPEND, 8'hFF, '0);
    write_group(7'd3);
    send_item(ACT_QUERY, 8'h00, 19'd24);
    send_item(ACT_QUERY, 8'h00, 19'd40);

    // A few whole groups of ones with the widest group, queried across a full scan.
    write_group(7'd64);
    send_item(ACT_CLEAR, 8'h00, '0);
    repeat (130) send_item(ACT_APPEND, 8'hFF, '0);
    send_item(ACT_QUERY, 8'h00, '1);
    send_item(ACT_QUERY, 8'h00, 19'd1040);
    send_item(ACT_QUERY, 8'h00, 19'd1039);
    send_item(ACT_QUERY, 8'h00, 19'd1023);
    send_item(ACT_QUERY, 8'h00, 19'd512);
    send_item(ACT_QUERY, 8'h00, 19'd0);
    send_item(ACT_CLEAR, 8'h00, '0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: phase_group = 7'd1;
        1: phase_group = 7'd64;
        2: phase_group = 7'd0;
        3: phase_group = 7'd127;
        4: phase_group = 7'd8;
        5: phase_group = GROUP_W'($urandom_range(63, 2));
        6: phase_group = GROUP_W'($urandom_range(127));
        default: phase_group = 7'd2;
      endcase
      write_group(phase_group);
      set_idle(idle_mode_t'(phase % 4));
      if ($urandom_range(1) == 0) send_item(ACT_CLEAR, 8'h00, '0);
      repeat (225) send_random_item();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
